// ----- rtl/dcim_pkg.sv -----
// ----------------------------------------------------------------------------
// dcim_pkg
// Shared types and constants for the drive command input mapper: field
// widths, key and mode bit positions, register indexes and lane command.
// ----------------------------------------------------------------------------
package dcim_pkg;

   // field widths
   localparam int OUT_W      = 19;
   localparam int MAG_W      = 18;
   localparam int MAX_W      = 16;
   localparam int SCALE_W    = 10;
   localparam int DB_W       = 10;
   localparam int AXMAX_W    = 11;
   localparam int MODE_W     = 6;
   localparam int SRC_W      = 2;
   localparam int SWITCH_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // fixed point
   localparam int Q_ONE    = 32768;
   localparam int Q_FRAC   = 15;
   localparam int KEY_FRAC = 8;

   // key bitmap positions
   localparam int KEY_W_BIT     = 0;
   localparam int KEY_S_BIT     = 1;
   localparam int KEY_A_BIT     = 2;
   localparam int KEY_D_BIT     = 3;
   localparam int KEY_SHIFT_BIT = 4;
   localparam int KEY_CTRL_BIT  = 5;
   localparam int KEY_Q_BIT     = 6;
   localparam int KEY_E_BIT     = 7;
   localparam int KEY_F_BIT     = 9;

   // mode flag positions
   localparam int MODE_KBD_EN    = 0;
   localparam int MODE_STICK_EN  = 1;
   localparam int MODE_STICK_YAW = 2;
   localparam int MODE_NEG_FWD   = 3;
   localparam int MODE_NEG_SIDE  = 4;
   localparam int MODE_NEG_TURN  = 5;

   // command source codes
   localparam logic [SRC_W-1:0] SRC_NONE  = 2'd0;
   localparam logic [SRC_W-1:0] SRC_STICK = 2'd1;
   localparam logic [SRC_W-1:0] SRC_KEY   = 2'd2;

   // switch position meaning up
   localparam logic [SWITCH_W-1:0] SWITCH_UP = 2'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FWD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SIDE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TURN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_FLAGS = 3'd7;

   // register reset values
   localparam logic [DB_W-1:0]    DEADBAND_RST = 10'd10;
   localparam logic [AXMAX_W-1:0] AXMAX_RST    = 11'd660;
   localparam logic [SCALE_W-1:0] SCALE_ONE    = 10'd256;
   localparam logic [MODE_W-1:0]  MODE_RST     = 6'd3;

   // what one lane does with the current frame
   typedef enum logic [1:0] {
      LANE_OFF,
      LANE_KEY,
      LANE_STICK
   } dcim_lane_mode_type;

   typedef struct packed {
      dcim_lane_mode_type         mode;
      logic                       invert;
      logic [SCALE_W-1:0]         scale;
      logic [MAX_W-1:0]           max_val;
   } dcim_lane_cmd_type;

   typedef struct packed {
      logic [DB_W-1:0]            deadband;
      logic [AXMAX_W-1:0]         axis_max;
   } dcim_stick_cfg_type;

endpackage

// ----- rtl/dcim_lane.sv -----
// ----------------------------------------------------------------------------
// dcim_lane
// One axis of the mapper. Stick mode: deadband removal, bit-serial restoring
// division into Q1.15, saturation and scaling. Keyboard mode: speed scaling.
// ----------------------------------------------------------------------------
module dcim_lane #(
   parameter int STICK_BITS = 11
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               take,
   input  dcim_pkg::dcim_lane_cmd_type        cmd,
   input  dcim_pkg::dcim_stick_cfg_type       stick_cfg,
   input  logic signed [STICK_BITS-1:0]       stick_value,
   output logic                               done,
   output logic signed [dcim_pkg::OUT_W-1:0]  result
);
   import dcim_pkg::*;

   localparam int MW    = (STICK_BITS > DB_W) ? STICK_BITS : DB_W;
   localparam int QW    = MW + Q_FRAC;
   localparam int CNT_W = $clog2(QW);
   localparam int OPA_W = Q_FRAC + 2;
   localparam int PW    = OPA_W + MAX_W;

   typedef enum logic [4:0] {
      L_IDLE = 5'b00001,
      L_DIV  = 5'b00010,
      L_MUL  = 5'b00100,
      L_NORM = 5'b01000,
      L_DONE = 5'b10000
   } dcim_lane_state_type;

   dcim_lane_state_type state_ff, state_in;

   logic [QW-1:0]          num_ff, num_in;
   logic [AXMAX_W-1:0]     rem_ff, rem_in;
   logic [AXMAX_W-1:0]     den_ff, den_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [MAX_W-1:0]       max_ff, max_in;
   logic                   invert_ff, invert_in;
   logic                   shift8_ff, shift8_in;
   logic [PW-1:0]          prod_ff, prod_in;
   logic [OUT_W-1:0]       res_ff, res_in;

   logic [STICK_BITS-1:0]  raw;
   logic [STICK_BITS-1:0]  a_abs;
   logic [MW-1:0]          a_ext;
   logic [MW-1:0]          d_ext;
   logic [MW-1:0]          diff;
   logic                   a_lt_d;
   logic [AXMAX_W:0]       den_full;
   logic                   den_pos;
   logic [AXMAX_W:0]       trial;
   logic                   trial_ge;
   logic [OPA_W-1:0]       a_sel;
   logic [MAG_W-1:0]       mag;
   logic [OUT_W-1:0]       mag_ext;

   // stick magnitude against the deadband
   always_comb begin
      raw      = stick_value;
      a_abs    = raw[STICK_BITS-1] ? STICK_BITS'(~raw + 1'b1) : raw;
      a_ext    = MW'(a_abs);
      d_ext    = MW'(stick_cfg.deadband);
      a_lt_d   = a_ext < d_ext;
      diff     = a_ext - d_ext;
      den_full = {1'b0, stick_cfg.axis_max} - (AXMAX_W+1)'(stick_cfg.deadband);
      den_pos  = !den_full[AXMAX_W] && (den_full != '0);
   end

   // one quotient bit per cycle
   always_comb begin
      trial    = {rem_ff, num_ff[QW-1]};
      trial_ge = trial >= {1'b0, den_ff};
   end

   // multiplier operand, quotient saturated to one
   always_comb begin
      a_sel = (num_ff > QW'(Q_ONE)) ? OPA_W'(Q_ONE) : num_ff[OPA_W-1:0];
   end

   // drop the fraction and widen to the result width
   always_comb begin
      mag     = shift8_ff ? prod_ff[KEY_FRAC +: MAG_W] : prod_ff[Q_FRAC +: MAG_W];
      mag_ext = {1'b0, mag};
   end

   // sequencer and datapath next values
   always_comb begin
      state_in  = state_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      max_in    = max_ff;
      invert_in = invert_ff;
      shift8_in = shift8_ff;
      prod_in   = prod_ff;
      res_in    = res_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               max_in    = cmd.max_val;
               invert_in = cmd.invert ^ ((cmd.mode == LANE_STICK) && raw[STICK_BITS-1]);
               shift8_in = cmd.mode == LANE_KEY;
               case (cmd.mode)
                  LANE_KEY: begin
                     num_in   = QW'(cmd.scale);
                     state_in = L_MUL;
                  end
                  LANE_STICK: begin
                     if (a_lt_d) begin
                        res_in   = '0;
                        state_in = L_DONE;
                     end else if (!den_pos) begin
                        if (diff != '0) begin
                           num_in   = QW'(Q_ONE);
                           state_in = L_MUL;
                        end else begin
                           res_in   = '0;
                           state_in = L_DONE;
                        end
                     end else begin
                        num_in   = {diff, {Q_FRAC{1'b0}}};
                        rem_in   = '0;
                        den_in   = den_full[AXMAX_W-1:0];
                        cnt_in   = CNT_W'(QW - 1);
                        state_in = L_DIV;
                     end
                  end
                  default: begin
                     res_in   = '0;
                     state_in = L_DONE;
                  end
               endcase
            end
         end
         L_DIV: begin
            rem_in = trial_ge ? AXMAX_W'(trial - {1'b0, den_ff}) : trial[AXMAX_W-1:0];
            num_in = {num_ff[QW-2:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = L_MUL;
            end
         end
         L_MUL: begin
            prod_in  = PW'(a_sel) * PW'(max_ff);
            state_in = L_NORM;
         end
         L_NORM: begin
            res_in   = invert_ff ? OUT_W'(~mag_ext + 1'b1) : mag_ext;
            state_in = L_DONE;
         end
         L_DONE: begin
            if (take) begin
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      cnt_ff    <= cnt_in;
      max_ff    <= max_in;
      invert_ff <= invert_in;
      shift8_ff <= shift8_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
   end

   assign done   = state_ff == L_DONE;
   assign result = res_ff;

   // a new frame only lands on an idle lane
   assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == L_IDLE)
      else $error("lane started while busy");

   // the last division step hands over to the multiplier
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == L_DIV) && (cnt_ff == '0) |=> state_ff == L_MUL)
      else $error("division did not end on count zero");

   // a finished result holds until it is taken
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == L_DONE) && !take |=> (state_ff == L_DONE) && $stable(res_ff))
      else $error("lane result lost before take");

   // a positive magnitude never comes out negative
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == L_NORM) && !invert_ff |=> !res_ff[OUT_W-1])
      else $error("lane result sign wrong");

endmodule

// ----- rtl/drive_command_input_mapper.sv -----
// A stick frame passes through the divider, multiplier and normalize steps of each lane
// before its rsp beat; frames without a stick division skip the divider.
// A new frame is taken only once the lanes have merged into the rsp register.
// A finished beat waits in the rsp register while the next frame is already taken.
// Reset (synchronous, active high) restores the register defaults, clears the
// keyboard toggle and the last F state, and empties the lanes and the rsp register.
// ----------------------------------------------------------------------------
// drive_command_input_mapper
// Maps remote-control frames to forward, sideways and turn commands from
// either the keyboard or the sticks, with three axis lanes and a merge stage.
// ----------------------------------------------------------------------------
module drive_command_input_mapper #(
   parameter int STICK_BITS = 11,
   parameter int KEY_BITS   = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_we,
   input  logic [dcim_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dcim_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // frame input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_link_online,
   input  logic signed [STICK_BITS-1:0]           req_stick_turn,
   input  logic signed [STICK_BITS-1:0]           req_stick_side,
   input  logic signed [STICK_BITS-1:0]           req_stick_fwd,
   input  logic [dcim_pkg::SWITCH_W-1:0]          req_switch_pos,
   input  logic [KEY_BITS-1:0]                    req_key_bits,
   // command output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [dcim_pkg::OUT_W-1:0]      rsp_fwd_cmd,
   output logic signed [dcim_pkg::OUT_W-1:0]      rsp_side_cmd,
   output logic signed [dcim_pkg::OUT_W-1:0]      rsp_turn_cmd,
   output logic                                   rsp_cmd_valid,
   output logic [dcim_pkg::SRC_W-1:0]             rsp_cmd_source,
   output logic                                   rsp_keyboard_mode
);
   import dcim_pkg::*;

   localparam int LANE_FWD  = 0;
   localparam int LANE_SIDE = 1;
   localparam int LANE_TURN = 2;
   localparam int LANES     = 3;

   // configuration registers
   logic [DB_W-1:0]     deadband_ff;
   logic [AXMAX_W-1:0]  axis_max_ff;
   logic [MAX_W-1:0]    max_fwd_ff;
   logic [MAX_W-1:0]    max_side_ff;
   logic [MAX_W-1:0]    max_turn_ff;
   logic [SCALE_W-1:0]  boost_ff;
   logic [SCALE_W-1:0]  slow_ff;
   logic [MODE_W-1:0]   mode_ff;

   // frame state and control
   logic                kact_ff, kact_in;
   logic                pf_ff, pf_in;
   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // sideband of the frame in the lanes
   logic                cmd_valid_ff, cmd_valid_in;
   logic [SRC_W-1:0]    src_ff, src_in;
   logic                kmode_ff, kmode_in;

   // rsp register
   logic [OUT_W-1:0]    rsp_fwd_ff, rsp_fwd_in;
   logic [OUT_W-1:0]    rsp_side_ff, rsp_side_in;
   logic [OUT_W-1:0]    rsp_turn_ff, rsp_turn_in;
   logic                rsp_cv_ff, rsp_cv_in;
   logic [SRC_W-1:0]    rsp_src_ff, rsp_src_in;
   logic                rsp_km_ff, rsp_km_in;

   logic                accept;
   logic                merge_fire;
   logic                up;
   logic                f_now;
   logic                use_kbd;
   logic                use_stick;
   logic [SCALE_W-1:0]  key_scale;
   logic [2:0]          key_pos;
   logic [2:0]          key_neg;
   logic [2:0]          key_flip;
   logic [MAX_W-1:0]    lane_max [LANES];

   dcim_lane_cmd_type           lane_cmd  [LANES];
   logic signed [STICK_BITS-1:0] lane_stick [LANES];
   logic                        lane_done [LANES];
   logic signed [OUT_W-1:0]     lane_res  [LANES];
   dcim_stick_cfg_type          stick_cfg;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = busy_ff;
   assign merge_fire = busy_ff && lane_done[LANE_FWD] && lane_done[LANE_SIDE]
                       && lane_done[LANE_TURN] && (!rsp_valid_ff || !rsp_stall);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= DEADBAND_RST;
         axis_max_ff <= AXMAX_RST;
         max_fwd_ff  <= '0;
         max_side_ff <= '0;
         max_turn_ff <= '0;
         boost_ff    <= SCALE_ONE;
         slow_ff     <= SCALE_ONE;
         mode_ff     <= MODE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEADBAND:   deadband_ff <= csr_wdata[DB_W-1:0];
            CSR_AXIS_MAX:   axis_max_ff <= csr_wdata[AXMAX_W-1:0];
            CSR_MAX_FWD:    max_fwd_ff  <= csr_wdata[MAX_W-1:0];
            CSR_MAX_SIDE:   max_side_ff <= csr_wdata[MAX_W-1:0];
            CSR_MAX_TURN:   max_turn_ff <= csr_wdata[MAX_W-1:0];
            CSR_BOOST:      boost_ff    <= csr_wdata[SCALE_W-1:0];
            CSR_SLOW:       slow_ff     <= csr_wdata[SCALE_W-1:0];
            CSR_MODE_FLAGS: mode_ff     <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // keyboard toggle and source choice for the incoming frame
   always_comb begin
      up    = req_switch_pos == SWITCH_UP;
      f_now = req_key_bits[KEY_F_BIT];
      if (!req_link_online) begin
         kact_in = 1'b0;
         pf_in   = 1'b0;
      end else begin
         kact_in = kact_ff ^ (f_now && !pf_ff && up);
         pf_in   = f_now;
      end
      if (!accept) begin
         kact_in = kact_ff;
         pf_in   = pf_ff;
      end
      use_kbd   = req_link_online && mode_ff[MODE_KBD_EN] && kact_in && up;
      use_stick = req_link_online && !use_kbd && mode_ff[MODE_STICK_EN] && up;
   end

   // speed factor from the modifier keys
   always_comb begin
      if (req_key_bits[KEY_SHIFT_BIT]) begin
         key_scale = boost_ff;
      end else if (req_key_bits[KEY_CTRL_BIT]) begin
         key_scale = slow_ff;
      end else begin
         key_scale = SCALE_ONE;
      end
   end

   // per-lane commands
   always_comb begin
      key_pos  = {req_key_bits[KEY_Q_BIT], req_key_bits[KEY_A_BIT], req_key_bits[KEY_W_BIT]};
      key_neg  = {req_key_bits[KEY_E_BIT], req_key_bits[KEY_D_BIT], req_key_bits[KEY_S_BIT]};
      key_flip = {mode_ff[MODE_NEG_TURN], mode_ff[MODE_NEG_SIDE], mode_ff[MODE_NEG_FWD]};
      lane_max[LANE_FWD]    = max_fwd_ff;
      lane_max[LANE_SIDE]   = max_side_ff;
      lane_max[LANE_TURN]   = max_turn_ff;
      lane_stick[LANE_FWD]  = req_stick_fwd;
      lane_stick[LANE_SIDE] = req_stick_side;
      lane_stick[LANE_TURN] = req_stick_turn;
      for (int i = 0; i < LANES; i++) begin
         lane_cmd[i].max_val = lane_max[i];
         lane_cmd[i].scale   = key_scale;
         if (use_kbd) begin
            lane_cmd[i].mode   = (key_pos[i] ^ key_neg[i]) ? LANE_KEY : LANE_OFF;
            lane_cmd[i].invert = (key_neg[i] && !key_pos[i]) ^ key_flip[i];
         end else if (use_stick) begin
            lane_cmd[i].mode   = LANE_STICK;
            lane_cmd[i].invert = i == LANE_FWD;
         end else begin
            lane_cmd[i].mode   = LANE_OFF;
            lane_cmd[i].invert = 1'b0;
         end
      end
      if (use_stick && !mode_ff[MODE_STICK_YAW]) begin
         lane_cmd[LANE_TURN].mode = LANE_OFF;
      end
   end

   assign stick_cfg.deadband = deadband_ff;
   assign stick_cfg.axis_max = axis_max_ff;

   // axis lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      dcim_lane #(
         .STICK_BITS (STICK_BITS)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .start       (accept),
         .take        (merge_fire),
         .cmd         (lane_cmd[g]),
         .stick_cfg   (stick_cfg),
         .stick_value (lane_stick[g]),
         .done        (lane_done[g]),
         .result      (lane_res[g])
      );
   end

   // frame tracking and merge into the rsp register
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_valid_in = cmd_valid_ff;
      src_in       = src_ff;
      kmode_in     = kmode_ff;
      rsp_fwd_in   = rsp_fwd_ff;
      rsp_side_in  = rsp_side_ff;
      rsp_turn_in  = rsp_turn_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_km_in    = rsp_km_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in      = 1'b1;
         cmd_valid_in = use_kbd || use_stick;
         src_in       = use_kbd ? SRC_KEY : (use_stick ? SRC_STICK : SRC_NONE);
         kmode_in     = use_kbd;
      end
      if (merge_fire) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_fwd_in   = lane_res[LANE_FWD];
         rsp_side_in  = lane_res[LANE_SIDE];
         rsp_turn_in  = lane_res[LANE_TURN];
         rsp_cv_in    = cmd_valid_ff;
         rsp_src_in   = src_ff;
         rsp_km_in    = kmode_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         kact_ff      <= 1'b0;
         pf_ff        <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kact_ff      <= kact_in;
         pf_ff        <= pf_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_valid_ff <= cmd_valid_in;
      src_ff       <= src_in;
      kmode_ff     <= kmode_in;
      rsp_fwd_ff   <= rsp_fwd_in;
      rsp_side_ff  <= rsp_side_in;
      rsp_turn_ff  <= rsp_turn_in;
      rsp_cv_ff    <= rsp_cv_in;
      rsp_src_ff   <= rsp_src_in;
      rsp_km_ff    <= rsp_km_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fwd_cmd       = rsp_fwd_ff;
   assign rsp_side_cmd      = rsp_side_ff;
   assign rsp_turn_cmd      = rsp_turn_ff;
   assign rsp_cmd_valid     = rsp_cv_ff;
   assign rsp_cmd_source    = rsp_src_ff;
   assign rsp_keyboard_mode = rsp_km_ff;

   // an offline frame clears the toggle state
   assert property (@(posedge clock) disable iff (reset)
      accept && !req_link_online |=> !kact_ff && !pf_ff)
      else $error("toggle state kept over an offline frame");

   // no source means a zero command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_cv_ff |->
         (rsp_fwd_ff == '0) && (rsp_side_ff == '0) && (rsp_turn_ff == '0)
         && (rsp_src_ff == SRC_NONE))
      else $error("motion without a command source");

   // keyboard mode flag agrees with the source code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_km_ff == (rsp_src_ff == SRC_KEY)))
      else $error("keyboard mode and source disagree");

   // a merge only happens with a frame in flight and leaves a beat behind
   assert property (@(posedge clock) disable iff (reset)
      merge_fire |=> rsp_valid_ff && !busy_ff)
      else $error("merged beat not presented");

endmodule

// ----- tb/sv/drive_command_input_mapper_test.sv -----
// ----------------------------------------------------------------------------
// drive_command_input_mapper_test
// Self-checking bench for the drive command input mapper. A directed script
// of frames and register writes runs first, then randomized phases with
// fresh register settings. Every rsp beat is compared against an expected
// command, written in the script or taken from a local model of the mapper,
// with random idle gaps on the req side and random stalls on the rsp side.
// ----------------------------------------------------------------------------
module drive_command_input_mapper_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dcim_pkg::*;

   localparam int STICK_W      = 11;
   localparam int KEYS_W       = 16;
   localparam int RAND_PHASES  = 10;
   localparam int PHASE_FRAMES = 100;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 600000;

   typedef struct packed {
      logic                      link;
      logic signed [STICK_W-1:0] turn;
      logic signed [STICK_W-1:0] side;
      logic signed [STICK_W-1:0] fwd;
      logic [SWITCH_W-1:0]       sw;
      logic [KEYS_W-1:0]         keys;
   } frame_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] fwd;
      logic signed [OUT_W-1:0] side;
      logic signed [OUT_W-1:0] turn;
      logic                    cmd_valid;
      logic [SRC_W-1:0]        source;
      logic                    kmode;
   } drive_cmd_type;

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  data;
      frame_type              f;
      logic                   typed;
      drive_cmd_type          want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_link_online = 1'b0;
   logic signed [STICK_W-1:0]    req_stick_turn = '0;
   logic signed [STICK_W-1:0]    req_stick_side = '0;
   logic signed [STICK_W-1:0]    req_stick_fwd = '0;
   logic [SWITCH_W-1:0]          req_switch_pos = '0;
   logic [KEYS_W-1:0]            req_key_bits = '0;

   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [OUT_W-1:0]      rsp_fwd_cmd;
   logic signed [OUT_W-1:0]      rsp_side_cmd;
   logic signed [OUT_W-1:0]      rsp_turn_cmd;
   logic                         rsp_cmd_valid;
   logic [SRC_W-1:0]             rsp_cmd_source;
   logic                         rsp_keyboard_mode;

   drive_command_input_mapper #(
      .STICK_BITS(STICK_W),
      .KEY_BITS  (KEYS_W)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_link_online  (req_link_online),
      .req_stick_turn   (req_stick_turn),
      .req_stick_side   (req_stick_side),
      .req_stick_fwd    (req_stick_fwd),
      .req_switch_pos   (req_switch_pos),
      .req_key_bits     (req_key_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fwd_cmd      (rsp_fwd_cmd),
      .rsp_side_cmd     (rsp_side_cmd),
      .rsp_turn_cmd     (rsp_turn_cmd),
      .rsp_cmd_valid    (rsp_cmd_valid),
      .rsp_cmd_source   (rsp_cmd_source),
      .rsp_keyboard_mode(rsp_keyboard_mode)
   );

   // shadow copy of the registers and the toggle state
   logic [DB_W-1:0]    cfg_deadband;
   logic [AXMAX_W-1:0] cfg_axis_max;
   logic [MAX_W-1:0]   cfg_max_fwd;
   logic [MAX_W-1:0]   cfg_max_side;
   logic [MAX_W-1:0]   cfg_max_turn;
   logic [SCALE_W-1:0] cfg_boost;
   logic [SCALE_W-1:0] cfg_slow;
   logic [MODE_W-1:0]  cfg_mode;
   logic               kbd_toggle;
   logic               last_f;

   drive_cmd_type  pending_cmds[$];
   script_row_type script[$];

   int  errors = 0;
   int  frames_sent = 0;
   int  cmds_checked = 0;
   int  reg_writes = 0;
   int  kbd_beats = 0;
   int  stick_beats = 0;
   int  none_beats = 0;
   int  cycle_count = 0;
   bit  idle_off = 1'b0;

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d commands still expected",
                  cycle_count, pending_cmds.size());
         $display("drive_command_input_mapper: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // command model
   // ------------------------------------------------------------------

   // stick value to signed q1.15, deadband removed, saturated at one
   function automatic int stick_to_q15(logic signed [STICK_W-1:0] v);
      int sv, a, d, den, q;
      sv  = v;
      a   = (sv < 0) ? -sv : sv;
      d   = int'(cfg_deadband);
      den = int'(cfg_axis_max) - d;
      if (a < d) return 0;
      if (den <= 0) begin
         q = ((a - d) > 0) ? Q_ONE : 0;
      end else begin
         q = ((a - d) <<< Q_FRAC) / den;
         if (q > Q_ONE) q = Q_ONE;
      end
      return (sv < 0) ? -q : q;
   endfunction

   // q1.15 times full-scale speed, sign applied to the magnitude
   function automatic int apply_speed(int q, logic [MAX_W-1:0] mx);
      longint mag, r;
      mag = (q < 0) ? -q : q;
      r   = (mag * longint'(mx)) >>> Q_FRAC;
      return (q < 0) ? -int'(r) : int'(r);
   endfunction

   // unit key direction times the scaled speed
   function automatic int key_speed(logic [KEYS_W-1:0] keys, int pos, int neg,
                                    logic negate, logic [SCALE_W-1:0] scale,
                                    logic [MAX_W-1:0] mx);
      int dir, mag;
      dir = 0;
      mag = (int'(scale) * int'(mx)) >>> KEY_FRAC;
      if (keys[pos]) dir += 1;
      if (keys[neg]) dir -= 1;
      if (negate) dir = -dir;
      return dir * mag;
   endfunction

   // one frame in, one command out; updates the toggle state
   function automatic drive_cmd_type map_frame(frame_type f);
      drive_cmd_type      r;
      logic               up, f_now;
      logic [SCALE_W-1:0] scale;
      r     = '0;
      up    = (f.sw == SWITCH_UP);
      f_now = f.keys[KEY_F_BIT];
      if (!f.link) begin
         kbd_toggle = 1'b0;
         last_f     = 1'b0;
      end else begin
         if (f_now && !last_f && up) kbd_toggle = !kbd_toggle;
         last_f = f_now;
         if (cfg_mode[MODE_KBD_EN] && kbd_toggle && up) begin
            if (f.keys[KEY_SHIFT_BIT])      scale = cfg_boost;
            else if (f.keys[KEY_CTRL_BIT])  scale = cfg_slow;
            else                            scale = SCALE_ONE;
            r.fwd  = OUT_W'(key_speed(f.keys, KEY_W_BIT, KEY_S_BIT,
                                      cfg_mode[MODE_NEG_FWD], scale, cfg_max_fwd));
            r.side = OUT_W'(key_speed(f.keys, KEY_A_BIT, KEY_D_BIT,
                                      cfg_mode[MODE_NEG_SIDE], scale, cfg_max_side));
            r.turn = OUT_W'(key_speed(f.keys, KEY_Q_BIT, KEY_E_BIT,
                                      cfg_mode[MODE_NEG_TURN], scale, cfg_max_turn));
            r.cmd_valid = 1'b1;
            r.source    = SRC_KEY;
            r.kmode     = 1'b1;
         end else if (cfg_mode[MODE_STICK_EN] && up) begin
            // forward stick is inverted
            r.fwd  = OUT_W'(-apply_speed(stick_to_q15(f.fwd), cfg_max_fwd));
            r.side = OUT_W'(apply_speed(stick_to_q15(f.side), cfg_max_side));
            if (cfg_mode[MODE_STICK_YAW])
               r.turn = OUT_W'(apply_speed(stick_to_q15(f.turn), cfg_max_turn));
            r.cmd_valid = 1'b1;
            r.source    = SRC_STICK;
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic frame_type mk_frame(logic link, int turn, int side, int fwd,
                                          int sw, int keys);
      frame_type f;
      f.link = link;
      f.turn = STICK_W'(turn);
      f.side = STICK_W'(side);
      f.fwd  = STICK_W'(fwd);
      f.sw   = SWITCH_W'(sw);
      f.keys = KEYS_W'(keys);
      return f;
   endfunction

   function automatic drive_cmd_type mk_cmd(int fwd, int side, int turn, logic cv,
                                            logic [SRC_W-1:0] src, logic km);
      drive_cmd_type c;
      c.fwd       = OUT_W'(fwd);
      c.side      = OUT_W'(side);
      c.turn      = OUT_W'(turn);
      c.cmd_valid = cv;
      c.source    = src;
      c.kmode     = km;
      return c;
   endfunction

   function automatic void add_frame(frame_type f);
      script.push_back('{ROW_FRAME, '0, '0, f, 1'b0, '0});
   endfunction

   function automatic void add_typed(frame_type f, drive_cmd_type c);
      script.push_back('{ROW_FRAME, '0, '0, f, 1'b1, c});
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, int data);
      script.push_back('{ROW_CSR, idx, CSR_DATA_W'(data), '0, 1'b0, '0});
   endfunction

   // stick value aimed at the extremes, zero, the deadband edge and full scale, or uniform
   function automatic logic signed [STICK_W-1:0] pick_stick();
      int pick, base, v;
      pick = $urandom_range(0, 9);
      case (pick)
         0: v = -1024;
         1: v = 1023;
         2: v = int'($urandom_range(0, 2)) - 1;
         3, 4: begin
            base = int'(cfg_deadband) + int'($urandom_range(0, 4)) - 2;
            if (base < 0) base = 0;
            if (base > 1023) base = 1023;
            v = $urandom_range(0, 1) ? -base : base;
         end
         5: begin
            base = int'(cfg_axis_max) + int'($urandom_range(0, 4)) - 2;
            if (base < 0) base = 0;
            if (base > 1023) base = 1023;
            v = $urandom_range(0, 1) ? -base : base;
         end
         default: v = int'($urandom_range(0, 2047)) - 1024;
      endcase
      return STICK_W'(v);
   endfunction

   // mostly online frames with the switch up, so both sources get exercised
   function automatic frame_type random_frame();
      frame_type f;
      f.link = ($urandom_range(0, 99) < 94);
      f.sw   = ($urandom_range(0, 99) < 75) ? SWITCH_UP : SWITCH_W'($urandom_range(0, 3));
      f.keys = KEYS_W'($urandom_range(0, 65535));
      f.keys[KEY_F_BIT] = ($urandom_range(0, 9) < 3);
      f.turn = pick_stick();
      f.side = pick_stick();
      f.fwd  = pick_stick();
      return f;
   endfunction

   // register value: an extreme half of the time
   function automatic int pick_reg(int lo, int hi);
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return lo;
      if (r == 1) return hi;
      return $urandom_range(lo, hi);
   endfunction

   // lower valid and wait until every expected command has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_cmds.size() != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(negedge clock);
      csr_we <= 1'b0;
      reg_writes++;
      case (idx)
         CSR_DEADBAND:   cfg_deadband = data[DB_W-1:0];
         CSR_AXIS_MAX:   cfg_axis_max = data[AXMAX_W-1:0];
         CSR_MAX_FWD:    cfg_max_fwd  = data[MAX_W-1:0];
         CSR_MAX_SIDE:   cfg_max_side = data[MAX_W-1:0];
         CSR_MAX_TURN:   cfg_max_turn = data[MAX_W-1:0];
         CSR_BOOST:      cfg_boost    = data[SCALE_W-1:0];
         CSR_SLOW:       cfg_slow     = data[SCALE_W-1:0];
         CSR_MODE_FLAGS: cfg_mode     = data[MODE_W-1:0];
         default: ;
      endcase
   endtask

   // present one req beat after a random gap and hold it until accepted
   task automatic send_frame(frame_type f, logic typed, drive_cmd_type want);
      int            gap;
      drive_cmd_type pred;
      gap = idle_off ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_link_online <= f.link;
      req_stick_turn  <= f.turn;
      req_stick_side  <= f.side;
      req_stick_fwd   <= f.fwd;
      req_switch_pos  <= f.sw;
      req_key_bits    <= f.keys;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      pred = map_frame(f);
      pending_cmds.push_back(typed ? want : pred);
      frames_sent++;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // rsp side: random stalls with long stall-free stretches
   // ------------------------------------------------------------------
   int  rx_left = 0;
   bit  rx_stalling = 1'b0;

   always @(negedge clock) begin
      logic next_stall;
      next_stall = rx_stalling;
      if (rx_left != 0) begin
         rx_left--;
      end else if (rx_stalling) begin
         next_stall = 1'b0;
         rx_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 20);
      end else begin
         rx_left = pick_gap();
         next_stall = (rx_left != 0);
      end
      rx_stalling = next_stall;
      rsp_stall <= next_stall;
   end

   // rsp beat check against the oldest expectation
   always @(posedge clock) begin
      drive_cmd_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_fwd_cmd, rsp_side_cmd, rsp_turn_cmd, rsp_cmd_valid,
                rsp_cmd_source, rsp_keyboard_mode};
         cmds_checked++;
         case (got.source)
            SRC_KEY:   kbd_beats++;
            SRC_STICK: stick_beats++;
            default:   none_beats++;
         endcase
         if (pending_cmds.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected rsp beat: fwd %0d side %0d turn %0d valid %0b src %0d kbd %0b",
                        got.fwd, got.side, got.turn, got.cmd_valid, got.source, got.kmode);
         end else begin
            want = pending_cmds.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) begin
                  $display("command %0d differs:", cmds_checked);
                  $display("  want fwd %0d side %0d turn %0d valid %0b src %0d kbd %0b",
                           want.fwd, want.side, want.turn, want.cmd_valid,
                           want.source, want.kmode);
                  $display("  got  fwd %0d side %0d turn %0d valid %0b src %0d kbd %0b",
                           got.fwd, got.side, got.turn, got.cmd_valid,
                           got.source, got.kmode);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int mode;

      // register defaults and cleared toggle, as after reset
      cfg_deadband = DEADBAND_RST;
      cfg_axis_max = AXMAX_RST;
      cfg_max_fwd  = '0;
      cfg_max_side = '0;
      cfg_max_turn = '0;
      cfg_boost    = SCALE_ONE;
      cfg_slow     = SCALE_ONE;
      cfg_mode     = MODE_RST;
      kbd_toggle   = 1'b0;
      last_f       = 1'b0;

      // defaults after reset: speed maxima are zero, so commands are zero
      add_typed(mk_frame(1'b0, 1023, -1024, 1023, 0, 16'hFFFF),
                mk_cmd(0, 0, 0, 1'b0, SRC_NONE, 1'b0));
      add_typed(mk_frame(1'b1, 1023, -1024, 0, 0, 0),
                mk_cmd(0, 0, 0, 1'b1, SRC_STICK, 1'b0));
      add_typed(mk_frame(1'b1, 500, 500, 500, 1, 0),
                mk_cmd(0, 0, 0, 1'b0, SRC_NONE, 1'b0));
      // switch code 3 acts like middle
      add_typed(mk_frame(1'b1, 500, 500, 500, 3, 0),
                mk_cmd(0, 0, 0, 1'b0, SRC_NONE, 1'b0));
      // F edge with switch up hands the drive to the keyboard
      add_typed(mk_frame(1'b1, 0, 0, 0, 0, 16'h0200),
                mk_cmd(0, 0, 0, 1'b1, SRC_KEY, 1'b1));
      add_typed(mk_frame(1'b1, 0, 0, 0, 0, 16'h0201),
                mk_cmd(0, 0, 0, 1'b1, SRC_KEY, 1'b1));

      // full speed maxima, wide boost, zero slow, yaw from stick
      add_csr(CSR_MAX_FWD, 16'hFFFF);
      add_csr(CSR_MAX_SIDE, 16'hFFFF);
      add_csr(CSR_MAX_TURN, 16'hFFFF);
      add_csr(CSR_BOOST, 1023);
      add_csr(CSR_SLOW, 0);
      add_csr(CSR_MODE_FLAGS, 7);
      add_frame(mk_frame(1'b1, 0, 0, 0, 0, 16'h0045));
      // opposing keys cancel
      add_frame(mk_frame(1'b1, 0, 0, 0, 0, 16'h00CF));
      add_frame(mk_frame(1'b1, 0, 0, 0, 0, 16'h0099));
      add_frame(mk_frame(1'b1, 0, 0, 0, 0, 16'h0066));
      // shift wins over ctrl
      add_frame(mk_frame(1'b1, 0, 0, 0, 0, 16'h0031));
      // F edge with switch in the middle does not toggle
      add_frame(mk_frame(1'b1, 0, 0, 0, 1, 16'h0200));
      add_frame(mk_frame(1'b1, 0, 0, 0, 0, 16'h0000));
      add_frame(mk_frame(1'b1, -1024, 1023, -1024, 0, 16'h0200));
      add_frame(mk_frame(1'b1, 0, 0, 0, 0, 16'h0000));
      // deadband edges
      add_frame(mk_frame(1'b1, 9, -10, 10, 0, 16'h0000));
      add_frame(mk_frame(1'b1, 660, -670, 1023, 0, 16'h0000));
      // link offline clears the toggle
      add_frame(mk_frame(1'b0, 100, 100, 100, 0, 16'h0200));

      // deadband above axis_max saturates, yaw off, keyboard axes negated
      add_csr(CSR_DEADBAND, 1023);
      add_csr(CSR_AXIS_MAX, 1);
      add_csr(CSR_MODE_FLAGS, 6'h3B);
      add_frame(mk_frame(1'b1, 1023, -1024, -1023, 0, 16'h0000));
      add_frame(mk_frame(1'b1, 0, 0, 0, 0, 16'h0255));
      add_frame(mk_frame(1'b1, 0, 0, 0, 0, 16'hFFFF));

      // nothing enabled; F still toggles underneath
      add_csr(CSR_MODE_FLAGS, 0);
      add_csr(CSR_DEADBAND, 0);
      add_csr(CSR_AXIS_MAX, 1024);
      add_frame(mk_frame(1'b1, 0, 0, 0, 0, 16'h0000));
      add_frame(mk_frame(1'b1, 0, 0, 0, 0, 16'h0200));
      // keyboard toggled off and disabled, sticks take over
      add_csr(CSR_MODE_FLAGS, 6);
      add_frame(mk_frame(1'b1, -1024, 1023, -1024, 0, 16'h0000));

      // reset, once
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed script
      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR)
            write_reg(script[i].idx, int'(script[i].data));
         else
            send_frame(script[i].f, script[i].typed, script[i].want);
      end

      // random phases, each with a fresh register setting
      for (int p = 0; p < RAND_PHASES; p++) begin
         idle_off = (p % 3 == 2);
         if (p == 0) begin
            write_reg(CSR_DEADBAND, 0);
            write_reg(CSR_AXIS_MAX, 1024);
            write_reg(CSR_MAX_FWD, 16'hFFFF);
            write_reg(CSR_MAX_SIDE, 16'hFFFF);
            write_reg(CSR_MAX_TURN, 16'hFFFF);
            write_reg(CSR_BOOST, 1023);
            write_reg(CSR_SLOW, 1023);
            write_reg(CSR_MODE_FLAGS, 63);
         end else if (p == 1) begin
            write_reg(CSR_DEADBAND, 1023);
            write_reg(CSR_AXIS_MAX, 1);
            write_reg(CSR_MAX_FWD, 0);
            write_reg(CSR_MAX_SIDE, 1);
            write_reg(CSR_MAX_TURN, 16'hFFFF);
            write_reg(CSR_BOOST, 0);
            write_reg(CSR_SLOW, 1);
            write_reg(CSR_MODE_FLAGS, 7);
         end else begin
            write_reg(CSR_DEADBAND, ($urandom_range(0, 1) != 0) ? $urandom_range(0, 60)
                                                                : pick_reg(0, 1023));
            write_reg(CSR_AXIS_MAX, pick_reg(1, 1024));
            write_reg(CSR_MAX_FWD, pick_reg(0, 65535));
            write_reg(CSR_MAX_SIDE, pick_reg(0, 65535));
            write_reg(CSR_MAX_TURN, pick_reg(0, 65535));
            write_reg(CSR_BOOST, pick_reg(0, 1023));
            write_reg(CSR_SLOW, pick_reg(0, 1023));
            mode = $urandom_range(0, 63);
            if ($urandom_range(0, 1) != 0) mode = mode | 3;
            write_reg(CSR_MODE_FLAGS, mode);
         end
         for (int i = 0; i < PHASE_FRAMES; i++) begin
            // hold the sender until the pipeline has fully drained
            if (p == 4 && i == PHASE_FRAMES / 2) wait_idle();
            send_frame(random_frame(), 1'b0, '0);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_cmds.size() != 0) begin
         $display("%0d commands never arrived", pending_cmds.size());
         errors += pending_cmds.size();
      end

      $display("%0d frames over %0d register writes, %0d commands checked, %0d errors",
               frames_sent, reg_writes, cmds_checked, errors);
      $display("command sources: keyboard %0d, sticks %0d, none %0d",
               kbd_beats, stick_beats, none_beats);
      if (errors == 0)
         $display("drive_command_input_mapper: match");
      else
         $display("drive_command_input_mapper: mismatch");
      $finish;
   end

endmodule

// ----- drive_command_input_mapper.f -----
rtl/dcim_pkg.sv
rtl/dcim_lane.sv
rtl/drive_command_input_mapper.sv
tb/sv/drive_command_input_mapper_test.sv
